// File: hdl/assert_macros.svh
// Assertion macros shared by the calibrator RTL files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/ptfc_pkg.sv
// Package for the PIT/TSC frequency calibrator: types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ptfc_pkg;

    localparam int unsigned STAMP_W = 64;
    localparam int unsigned REF_W   = 21;
    localparam int unsigned DIV_W   = 26;
    localparam int unsigned MUL_W   = 53;
    localparam int unsigned NUM_W   = 85;
    localparam int unsigned QUO_W   = 32;
    localparam int unsigned CNT_W   = 5;

    localparam logic [REF_W-1:0] REF_HZ       = REF_W'(1193182);
    localparam logic [DIV_W-1:0] DIV_PER_STEP = DIV_W'(256000);
    localparam logic [QUO_W-1:0] KHZ_MAX      = '1;
    localparam logic [7:0]       TOP_BYTE     = 8'hff;
    localparam logic [7:0]       VERIFY_TOP   = 8'hfe;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CFG_MAX_ITER   = 8'd0;
    localparam logic [7:0] CFG_MIN_MATCH  = 8'd1;
    localparam logic [7:0] CFG_MATCH_CAP  = 8'd2;
    localparam logic [7:0] CFG_ERR_SHIFT  = 8'd3;

    localparam logic [7:0]  RST_MAX_ITER  = 8'd116;
    localparam logic [7:0]  RST_MIN_MATCH = 8'd5;
    localparam logic [15:0] RST_MATCH_CAP = 16'd50000;
    localparam logic [5:0]  RST_ERR_SHIFT = 6'd11;

    typedef enum logic [1:0] {
        PH_DISCARD = 2'd0,
        PH_MEASURE = 2'd1,
        PH_VERIFY  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FEW    = 2'd1,
        ST_ITER   = 2'd2,
        ST_VERIFY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE  = 2'd0,
        F_CLOSE = 2'd1,
        F_CHECK = 2'd2
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE = 4'd0,
        B_DIFF = 4'd1,
        B_ADJ  = 4'd2,
        B_MLO  = 4'd3,
        B_MHI  = 4'd4,
        B_SUM  = 4'd5,
        B_SAT  = 4'd6,
        B_DIV  = 4'd7,
        B_DONE = 4'd8
    } back_state_t;

    typedef struct packed {
        logic [7:0]  max_iterations;
        logic [7:0]  min_matches;
        logic [15:0] match_cap;
        logic [5:0]  error_shift;
    } cfg_t;

    typedef struct packed {
        status_t              status;
        logic [7:0]           step;
        logic [STAMP_W-1:0]   elapsed;
        logic [STAMP_W-1:0]   first_error;
        logic [STAMP_W-1:0]   current_error;
    } job_t;

endpackage

`default_nettype wire

// File: hdl/ptfc_front.sv
// Front end of the calibrator: takes samples, tracks byte windows and errors.
// Depends on ptfc_pkg; hands finished runs to the job queue.
`default_nettype none

module ptfc_front import ptfc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_timer_high_byte,
    input  wire logic [STAMP_W-1:0] s_cycle_stamp,
    input  wire logic               q_full,
    output logic                    push,
    output job_t                    push_job
);

    front_state_t       fstate_reg, fstate_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         step_reg, step_next;
    logic [15:0]        match_reg, match_next;
    logic [STAMP_W-1:0] last_reg, last_next;
    logic [STAMP_W-1:0] first_stamp_reg, first_stamp_next;
    logic [STAMP_W-1:0] first_err_reg, first_err_next;
    logic [STAMP_W-1:0] cur_err_reg, cur_err_next;
    logic [STAMP_W-1:0] elapsed_reg, elapsed_next;
    logic [STAMP_W-1:0] sum_reg, sum_next;

    logic               accept;
    logic               byte_hit;
    logic               verify_hit;
    logic [15:0]        match_inc;
    logic               cap_hit;
    logic               few;
    logic [8:0]         step_inc;
    logic               iter_out;
    logic               err_ok;
    logic [STAMP_W:0]   err_sum;

    assign s_ready    = (fstate_reg == F_IDLE) && !q_full;
    assign accept     = s_valid && s_ready;
    assign byte_hit   = s_timer_high_byte == (TOP_BYTE - step_reg);
    assign verify_hit = s_timer_high_byte == (VERIFY_TOP - step_reg);
    assign match_inc  = match_reg + 16'd1;
    assign cap_hit    = match_inc >= cfg.match_cap;
    assign few        = match_reg <= {8'd0, cfg.min_matches};
    assign step_inc   = {1'b0, step_reg} + 9'd1;
    assign iter_out   = step_inc >= {1'b0, cfg.max_iterations};
    assign err_ok     = sum_reg < (elapsed_reg >> cfg.error_shift);
    assign err_sum    = {1'b0, first_err_reg} + {1'b0, cur_err_reg};

    always_comb begin
        fstate_next = fstate_reg;
        case (fstate_reg)
            F_IDLE: begin
                if (accept && phase_reg == PH_MEASURE && (!byte_hit || cap_hit)) begin
                    fstate_next = F_CLOSE;
                end
            end
            F_CLOSE: begin
                if (few || step_reg == 8'd0) begin
                    fstate_next = F_IDLE;
                end else begin
                    fstate_next = F_CHECK;
                end
            end
            F_CHECK: fstate_next = F_IDLE;
            default: fstate_next = F_IDLE;
        endcase
    end

    always_comb begin
        push                   = 1'b0;
        push_job.status        = ST_OK;
        push_job.step          = step_reg;
        push_job.elapsed       = elapsed_reg;
        push_job.first_error   = first_err_reg;
        push_job.current_error = cur_err_reg;
        case (fstate_reg)
            F_IDLE: begin
                if (accept && phase_reg == PH_VERIFY) begin
                    push            = 1'b1;
                    push_job.status = verify_hit ? ST_OK : ST_VERIFY;
                end
            end
            F_CLOSE: begin
                if (few) begin
                    push            = 1'b1;
                    push_job.status = ST_FEW;
                end else if (step_reg == 8'd0 && iter_out) begin
                    push            = 1'b1;
                    push_job.status = ST_ITER;
                end
            end
            F_CHECK: begin
                if (!err_ok && iter_out) begin
                    push            = 1'b1;
                    push_job.status = ST_ITER;
                end
            end
            default: push = 1'b0;
        endcase
    end

    always_comb begin
        phase_next       = phase_reg;
        step_next        = step_reg;
        match_next       = match_reg;
        last_next        = last_reg;
        first_stamp_next = first_stamp_reg;
        first_err_next   = first_err_reg;
        cur_err_next     = cur_err_reg;
        elapsed_next     = elapsed_reg;
        sum_next         = sum_reg;
        case (fstate_reg)
            F_IDLE: begin
                if (accept) begin
                    case (phase_reg)
                        PH_DISCARD: begin
                            step_next  = 8'd0;
                            match_next = 16'd0;
                            last_next  = '0;
                            phase_next = PH_MEASURE;
                        end
                        PH_MEASURE: begin
                            if (byte_hit) begin
                                match_next = match_inc;
                                last_next  = s_cycle_stamp;
                                if (cap_hit) begin
                                    cur_err_next = '0;
                                end
                            end else begin
                                cur_err_next = s_cycle_stamp - last_reg;
                            end
                        end
                        PH_VERIFY: phase_next = PH_DISCARD;
                        default:   phase_next = PH_DISCARD;
                    endcase
                end
            end
            F_CLOSE: begin
                if (few) begin
                    phase_next = PH_DISCARD;
                end else if (step_reg == 8'd0) begin
                    first_stamp_next = last_reg;
                    first_err_next   = cur_err_reg;
                    if (iter_out) begin
                        phase_next = PH_DISCARD;
                    end else begin
                        step_next  = step_inc[7:0];
                        match_next = 16'd0;
                        last_next  = '0;
                    end
                end else begin
                    elapsed_next = last_reg - first_stamp_reg;
                    sum_next     = err_sum[STAMP_W] ? '1 : err_sum[STAMP_W-1:0];
                end
            end
            F_CHECK: begin
                if (err_ok) begin
                    phase_next = PH_VERIFY;
                end else if (iter_out) begin
                    phase_next = PH_DISCARD;
                end else begin
                    step_next  = step_inc[7:0];
                    match_next = 16'd0;
                    last_next  = '0;
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fstate_reg      <= F_IDLE;
            phase_reg       <= PH_DISCARD;
            step_reg        <= 8'd0;
            match_reg       <= 16'd0;
            last_reg        <= '0;
            first_stamp_reg <= '0;
            first_err_reg   <= '0;
            cur_err_reg     <= '0;
            elapsed_reg     <= '0;
            sum_reg         <= '0;
        end else begin
            fstate_reg      <= fstate_next;
            phase_reg       <= phase_next;
            step_reg        <= step_next;
            match_reg       <= match_next;
            last_reg        <= last_next;
            first_stamp_reg <= first_stamp_next;
            first_err_reg   <= first_err_next;
            cur_err_reg     <= cur_err_next;
            elapsed_reg     <= elapsed_next;
            sum_reg         <= sum_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ptfc_queue.sv
// Two-entry job queue between the calibrator front end and the divider.
// Depends on ptfc_pkg for the job type and depth; asserts via assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ptfc_queue import ptfc_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      empty
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full    = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_job = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_IMPL(a_no_push_full, aclk, aresetn, push, !full)
    `ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, !empty)

endmodule

`default_nettype wire

// File: hdl/ptfc_back.sv
// Back end of the calibrator: corrects the elapsed cycles, multiplies by the
// reference rate and divides bit by bit. Depends on ptfc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ptfc_back import ptfc_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    empty,
    output logic         pop,
    input  wire job_t    pop_job,
    output logic         m_valid,
    input  wire logic    m_ready,
    output logic [31:0]  m_freq_khz,
    output logic [1:0]   m_status
);

    back_state_t        bstate_reg, bstate_next;
    job_t               job_reg, job_next;
    logic               neg_reg, neg_next;
    logic [STAMP_W-1:0] half_reg, half_next;
    logic [STAMP_W-1:0] adj_reg, adj_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [MUL_W-1:0]   plo_reg, plo_next;
    logic [MUL_W-1:0]   phi_reg, phi_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [QUO_W-1:0]   res_freq_reg, res_freq_next;
    status_t            res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [QUO_W-1:0]   m_freq_reg, m_freq_next;
    status_t            m_status_reg, m_status_next;

    logic               out_free;
    logic               sat_hit;
    logic [DIV_W:0]     trial;
    logic               trial_ge;
    logic [STAMP_W:0]   adj_sum;
    logic [QUO_W-1:0]   quo_shift;

    assign out_free  = !m_valid_reg || m_ready;
    assign sat_hit   = (div_reg == '0) || (num_reg[NUM_W-1:QUO_W] >= {27'd0, div_reg});
    assign trial     = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_ge  = trial >= {1'b0, div_reg};
    assign quo_shift = {quo_reg[QUO_W-2:0], trial_ge};
    assign adj_sum   = {1'b0, job_reg.elapsed} + {1'b0, half_reg};

    assign m_valid    = m_valid_reg;
    assign m_freq_khz = m_freq_reg;
    assign m_status   = m_status_reg;

    always_comb begin
        bstate_next = bstate_reg;
        case (bstate_reg)
            B_IDLE: begin
                if (!empty) begin
                    bstate_next = (pop_job.status == ST_OK) ? B_DIFF : B_DONE;
                end
            end
            B_DIFF: bstate_next = B_ADJ;
            B_ADJ:  bstate_next = B_MLO;
            B_MLO:  bstate_next = B_MHI;
            B_MHI:  bstate_next = B_SUM;
            B_SUM:  bstate_next = B_SAT;
            B_SAT:  bstate_next = sat_hit ? B_DONE : B_DIV;
            B_DIV:  bstate_next = (cnt_reg == '1) ? B_DONE : B_DIV;
            B_DONE: bstate_next = out_free ? B_IDLE : B_DONE;
            default: bstate_next = B_IDLE;
        endcase
    end

    always_comb begin
        pop           = (bstate_reg == B_IDLE) && !empty;
        m_valid_next  = m_valid_reg;
        m_freq_next   = m_freq_reg;
        m_status_next = m_status_reg;
        if (bstate_reg == B_DONE && out_free) begin
            m_valid_next  = 1'b1;
            m_freq_next   = res_freq_reg;
            m_status_next = res_status_reg;
        end else if (m_ready) begin
            m_valid_next  = 1'b0;
        end
    end

    always_comb begin
        job_next        = job_reg;
        neg_next        = neg_reg;
        half_next       = half_reg;
        adj_next        = adj_reg;
        div_next        = div_reg;
        plo_next        = plo_reg;
        phi_next        = phi_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        res_freq_next   = res_freq_reg;
        res_status_next = res_status_reg;
        case (bstate_reg)
            B_IDLE: begin
                if (!empty) begin
                    job_next        = pop_job;
                    res_status_next = pop_job.status;
                    res_freq_next   = '0;
                end
            end
            B_DIFF: begin
                neg_next = job_reg.first_error > job_reg.current_error;
                if (job_reg.first_error > job_reg.current_error) begin
                    half_next = (job_reg.first_error - job_reg.current_error) >> 1;
                end else begin
                    half_next = (job_reg.current_error - job_reg.first_error) >> 1;
                end
                div_next = {18'd0, job_reg.step} * DIV_PER_STEP;
            end
            B_ADJ: begin
                if (!neg_reg) begin
                    adj_next = adj_sum[STAMP_W] ? '1 : adj_sum[STAMP_W-1:0];
                end else if (job_reg.elapsed >= half_reg) begin
                    adj_next = job_reg.elapsed - half_reg;
                end else begin
                    adj_next = '0;
                end
            end
            B_MLO: plo_next = {21'd0, adj_reg[31:0]} * {32'd0, REF_HZ};
            B_MHI: phi_next = {21'd0, adj_reg[63:32]} * {32'd0, REF_HZ};
            B_SUM: num_next = {phi_reg, 32'd0} + {32'd0, plo_reg};
            B_SAT: begin
                if (sat_hit) begin
                    res_freq_next = KHZ_MAX;
                end else begin
                    rem_next = num_reg[QUO_W+DIV_W-1:QUO_W];
                    quo_next = num_reg[QUO_W-1:0];
                    cnt_next = '0;
                end
            end
            B_DIV: begin
                rem_next = trial_ge ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
                quo_next = quo_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    res_freq_next = quo_shift;
                end
            end
            B_DONE: res_status_next = res_status_reg;
            default: res_status_next = res_status_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg        <= job_next;
        neg_reg        <= neg_next;
        half_reg       <= half_next;
        adj_reg        <= adj_next;
        div_reg        <= div_next;
        plo_reg        <= plo_next;
        phi_reg        <= phi_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        res_freq_reg   <= res_freq_next;
        res_status_reg <= res_status_next;
        m_freq_reg     <= m_freq_next;
        m_status_reg   <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bstate_reg  <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            bstate_reg  <= bstate_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_IMPL(a_rem_below_div, aclk, aresetn, bstate_reg == B_DIV, rem_reg < div_reg)
    `ASSERT_IMPL(a_fail_zero_freq, aclk, aresetn, m_valid_reg && m_status_reg != ST_OK, m_freq_reg == '0)

endmodule

`default_nettype wire

// File: hdl/pit_tsc_frequency_calibrator.sv
// While a window stays open, a sample is accepted whenever the job queue is not full; a sample
// that closes a window holds off the input while the front end checks the match count and,
// after the first step, the error bound. A finished run is queued, and the back end takes one
// job at a time through the two-step multiply and the 32-step restoring divider. Up to two
// finished runs wait in the queue while the result port is stalled.
// Top level of the PIT/TSC frequency calibrator: configuration registers and the
// front end, job queue and divider. Depends on ptfc_pkg and the ptfc_* modules.
`default_nettype none

module pit_tsc_frequency_calibrator import ptfc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_timer_high_byte,
    input  wire logic [STAMP_W-1:0] s_cycle_stamp,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [31:0]             m_freq_khz,
    output logic [1:0]              m_status
);

    cfg_t cfg_reg, cfg_next;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    job_t push_job;
    job_t pop_job;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MAX_ITER:  cfg_next.max_iterations = cfg_data[7:0];
                CFG_MIN_MATCH: cfg_next.min_matches    = cfg_data[7:0];
                CFG_MATCH_CAP: cfg_next.match_cap      = cfg_data;
                CFG_ERR_SHIFT: cfg_next.error_shift    = cfg_data[5:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_iterations <= RST_MAX_ITER;
            cfg_reg.min_matches    <= RST_MIN_MATCH;
            cfg_reg.match_cap      <= RST_MATCH_CAP;
            cfg_reg.error_shift    <= RST_ERR_SHIFT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ptfc_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_timer_high_byte (s_timer_high_byte),
        .s_cycle_stamp     (s_cycle_stamp),
        .q_full            (q_full),
        .push              (q_push),
        .push_job          (push_job)
    );

    ptfc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    ptfc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .empty      (q_empty),
        .pop        (q_pop),
        .pop_job    (pop_job),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_freq_khz (m_freq_khz),
        .m_status   (m_status)
    );

endmodule

`default_nettype wire

// File: test/tb_pit_tsc_frequency_calibrator.sv
`timescale 1ns / 100ps
// Testbench for pit_tsc_frequency_calibrator: drives timer sample streams and register writes,
// predicts each run's frequency and status, and checks every result transfer in order.
// Depends on ptfc_pkg and the calibrator RTL.

module tb_pit_tsc_frequency_calibrator;
    import ptfc_pkg::*;

    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [31:0] khz;
        status_t     status;
    } calib_result_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_timer_high_byte;
    logic [STAMP_W-1:0] s_cycle_stamp;
    logic               m_valid;
    logic               m_ready;
    logic [31:0]        m_freq_khz;
    logic [1:0]         m_status;

    pit_tsc_frequency_calibrator i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_timer_high_byte (s_timer_high_byte),
        .s_cycle_stamp     (s_cycle_stamp),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_freq_khz        (m_freq_khz),
        .m_status          (m_status)
    );

    always #5 aclk = ~aclk;

    cfg_t        cal_cfg      = '{RST_MAX_ITER, RST_MIN_MATCH, RST_MATCH_CAP, RST_ERR_SHIFT};
    phase_t      cal_phase    = PH_DISCARD;
    logic [7:0]  cal_step     = '0;
    logic [15:0] cal_count    = '0;
    logic [63:0] cal_last_hit = '0;
    logic [63:0] cal_base     = '0;
    logic [63:0] cal_err0     = '0;
    logic [63:0] cal_err1     = '0;
    logic [63:0] cal_span     = '0;

    calib_result_t predicted_results[$];
    int mismatch_count = 0;
    int runs_done      = 0;
    int items_sent     = 0;
    int sink_hold      = 0;
    bit tx_steady      = 1'b0;
    bit rx_steady      = 1'b0;

    function automatic logic [63:0] rand_stamp();
        return {$urandom, $urandom};
    endfunction

    function automatic void finish_run(input logic [31:0] khz, input status_t st);
        calib_result_t r;
        r.khz = khz;
        r.status = st;
        predicted_results.push_back(r);
        cal_phase = PH_DISCARD;
        runs_done++;
    endfunction

    function automatic void close_window();
        logic [63:0] err_sum;
        logic [8:0]  next_step;
        if (cal_count <= {8'd0, cal_cfg.min_matches}) begin
            finish_run(32'd0, ST_FEW);
            return;
        end
        if (cal_step == 8'd0) begin
            cal_base = cal_last_hit;
            cal_err0 = cal_err1;
        end else begin
            err_sum = cal_err0 + cal_err1;
            if (err_sum < cal_err0) err_sum = '1;
            cal_span = cal_last_hit - cal_base;
            if (err_sum < (cal_span >> cal_cfg.error_shift)) begin
                cal_phase = PH_VERIFY;
                return;
            end
        end
        next_step = {1'b0, cal_step} + 9'd1;
        if (next_step >= {1'b0, cal_cfg.max_iterations}) begin
            finish_run(32'd0, ST_ITER);
            return;
        end
        cal_step = next_step[7:0];
        cal_count = '0;
        cal_last_hit = '0;
    endfunction

    function automatic logic [31:0] khz_estimate();
        logic [63:0]  half, adj;
        logic [127:0] num, quo, divisor;
        divisor = {120'd0, cal_step} * 128'd256000;
        if (cal_err1 >= cal_err0) begin
            half = (cal_err1 - cal_err0) >> 1;
            adj = cal_span + half;
            if (adj < cal_span) adj = '1;
        end else begin
            half = (cal_err0 - cal_err1) >> 1;
            adj = (cal_span >= half) ? cal_span - half : 64'd0;
        end
        if (divisor == 128'd0) return 32'hffff_ffff;
        num = {64'd0, adj} * 128'd1193182;
        quo = num / divisor;
        return (quo > 128'hffff_ffff) ? 32'hffff_ffff : quo[31:0];
    endfunction

    function automatic void predict_sample(input logic [7:0] tb, input logic [63:0] ts);
        logic [7:0] want;
        case (cal_phase)
            PH_MEASURE: begin
                want = TOP_BYTE - cal_step;
                if (tb == want) begin
                    cal_count = cal_count + 16'd1;
                    cal_last_hit = ts;
                    if (cal_count >= cal_cfg.match_cap) begin
                        cal_err1 = '0;
                        close_window();
                    end
                end else begin
                    cal_err1 = ts - cal_last_hit;
                    close_window();
                end
            end
            PH_VERIFY: begin
                want = VERIFY_TOP - cal_step;
                if (tb == want) finish_run(khz_estimate(), ST_OK);
                else finish_run(32'd0, ST_VERIFY);
            end
            default: begin
                cal_step = '0;
                cal_count = '0;
                cal_last_hit = '0;
                cal_phase = PH_MEASURE;
            end
        endcase
    endfunction

    function automatic void apply_reg(input logic [7:0] idx, input logic [15:0] val);
        case (idx)
            CFG_MAX_ITER:  cal_cfg.max_iterations = val[7:0];
            CFG_MIN_MATCH: cal_cfg.min_matches = val[7:0];
            CFG_MATCH_CAP: cal_cfg.match_cap = val;
            CFG_ERR_SHIFT: cal_cfg.error_shift = val[5:0];
            default: ;
        endcase
    endfunction

    task automatic send_sample(input logic [7:0] tb, input logic [63:0] ts);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_timer_high_byte <= tb;
        s_cycle_stamp <= ts;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_sample(tb, ts);
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] mi, input logic [7:0] mm,
                              input logic [15:0] mc, input logic [5:0] es);
        settle();
        write_reg(CFG_MAX_ITER, {8'($urandom), mi});
        write_reg(CFG_MIN_MATCH, {8'($urandom), mm});
        write_reg(CFG_MATCH_CAP, mc);
        write_reg(CFG_ERR_SHIFT, {10'($urandom), es});
    endtask

    // Mismatching samples close windows until the run has produced its result.
    task automatic end_run();
        logic [7:0] want;
        while (cal_phase != PH_DISCARD) begin
            want = (cal_phase == PH_MEASURE) ? TOP_BYTE - cal_step : VERIFY_TOP - cal_step;
            send_sample(~want, rand_stamp());
        end
    endtask

    // One run against an ideal down-counting timer, with an occasional corrupted byte.
    task automatic drive_timer_run(input int per_lo, input int per_hi);
        logic [7:0]  tbyte, b;
        logic [63:0] tstamp, tick;
        int left, sent, runs_at;
        end_run();
        runs_at = runs_done;
        if ($urandom_range(0, 3) != 0) tick = 64'($urandom_range(1, 5000));
        else tick = (rand_stamp() >> $urandom_range(8, 62)) + 64'd1;
        tstamp = rand_stamp();
        tbyte = TOP_BYTE;
        left = $urandom_range(per_lo, per_hi);
        send_sample(8'($urandom), tstamp);
        sent = 0;
        while (runs_done == runs_at && sent < 300) begin
            tstamp = tstamp + tick + rand_stamp() % ((tick >> 2) + 64'd1);
            b = ($urandom_range(0, 59) == 0) ? 8'($urandom) : tbyte;
            send_sample(b, tstamp);
            sent++;
            left--;
            if (left == 0) begin
                tbyte = tbyte - 8'd1;
                left = $urandom_range(per_lo, per_hi);
            end
        end
    endtask

    task automatic test_directed_defaults();
        int i;
        logic [63:0] ts;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        send_sample(8'h00, 64'h0);
        send_sample(8'h00, 64'hffff_ffff_ffff_ffff);
        send_sample(8'hff, 64'hffff_ffff_ffff_fff0);
        ts = 64'hffff_ffff_ffff_fffa;
        for (i = 0; i < 7; i++) begin
            send_sample(TOP_BYTE, ts);
            ts = ts + 64'd3;
        end
        send_sample(VERIFY_TOP, ts);
        for (i = 0; i < 6; i++) begin
            ts = ts + 64'd3;
            send_sample(VERIFY_TOP, ts);
        end
        send_sample(8'h01, ts + 64'd5);
        end_run();
    endtask

    task automatic test_timer_runs(input logic [7:0] mi, input logic [7:0] mm,
                                   input logic [15:0] mc, input logic [5:0] es,
                                   input int per_lo, input int per_hi, input int budget);
        int start;
        bit paused;
        set_config(mi, mm, mc, es);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        start = items_sent;
        paused = 1'b0;
        while (items_sent < start + budget) begin
            if (!paused && items_sent >= start + budget / 2) begin
                settle();
                paused = 1'b1;
            end
            drive_timer_run(per_lo, per_hi);
        end
    endtask

    // Every second sample finishes a run, so a held result port fills the job queue.
    task automatic test_stalled_output();
        int k;
        set_config(8'd255, 8'd255, 16'd1, 6'd63);
        end_run();
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        sink_hold = 400;
        for (k = 0; k < 60; k++) send_sample(k[0] ? TOP_BYTE : 8'($urandom), rand_stamp());
    endtask

    task automatic test_unused_index();
        settle();
        write_reg(8'hff, 16'($urandom));
        write_reg(8'($urandom_range(4, 254)), 16'hffff);
        write_reg(8'd4, 16'h0000);
        repeat (4) drive_timer_run(4, 9);
    endtask

    task automatic test_random_noise(input int budget);
        int start;
        logic [7:0] b;
        set_config(8'($urandom_range(2, 255)), 8'($urandom_range(0, 3)),
                   16'($urandom_range(1, 20)), 6'($urandom_range(0, 63)));
        end_run();
        start = items_sent;
        while (items_sent < start + budget) begin
            case ($urandom_range(0, 3))
                0: b = 8'($urandom);
                1: b = VERIFY_TOP - cal_step;
                default: b = TOP_BYTE - cal_step;
            endcase
            send_sample(b, rand_stamp());
        end
    endtask

    initial begin : result_sink
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
            end
            gap = rx_steady ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    always @(posedge aclk) begin : result_check
        calib_result_t head;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (predicted_results.size() == 0) begin
                $display("%0t: unexpected result transfer, freq_khz %0d status %0d",
                         $time, m_freq_khz, m_status);
                mismatch_count++;
            end else begin
                head = predicted_results.pop_front();
                if (m_freq_khz !== head.khz) begin
                    $display("%0t: freq_khz expected %0d actual %0d",
                             $time, head.khz, m_freq_khz);
                    mismatch_count++;
                end
                if (m_status !== head.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, head.status, m_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("tb_pit_tsc_frequency_calibrator: FAIL");
        $finish;
    end

    initial begin : main_sequence
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_timer_high_byte <= '0;
        s_cycle_stamp <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_defaults();
        test_timer_runs(8'd116, 8'd5, 16'd50000, 6'd2, 6, 12, 300);
        test_timer_runs(8'd2, 8'd0, 16'd65535, 6'd0, 1, 6, 200);
        test_stalled_output();
        test_timer_runs(8'd255, 8'd255, 16'd1, 6'd63, 1, 3, 150);
        test_timer_runs(8'd0, 8'd0, 16'd0, 6'd5, 2, 8, 80);
        test_timer_runs(8'd1, 8'd2, 16'd100, 6'd5, 3, 8, 80);
        test_timer_runs(8'd200, 8'd3, 16'd6, 6'd1, 4, 8, 200);
        test_unused_index();
        repeat (3) begin
            test_timer_runs(8'($urandom_range(2, 255)), 8'($urandom_range(0, 8)),
                            ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 65535))
                                                        : 16'($urandom_range(1, 12)),
                            6'($urandom_range(0, 5)), 3, 10, 150);
        end
        test_random_noise(150);
        test_timer_runs(RST_MAX_ITER, RST_MIN_MATCH, RST_MATCH_CAP, RST_ERR_SHIFT, 6, 12, 100);
        end_run();
        settle();
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("tb_pit_tsc_frequency_calibrator: PASS");
        end else begin
            $display("tb_pit_tsc_frequency_calibrator: FAIL");
        end
        $finish;
    end

endmodule
